@@ rtl/erht_pkg.sv @@
package erht_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_COUNTED    = 3'd0,
    ST_SHORT      = 3'd1,
    ST_FOREIGN    = 3'd2,
    ST_BAD_INDEX  = 3'd3,
    ST_OWN_ECHO   = 3'd4,
    ST_UNREACH    = 3'd5,
    ST_UNEXPECTED = 3'd6,
    ST_QUERY      = 3'd7
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_ID      = 2'd0;
  localparam logic [1:0] CFG_HOST_TOTAL  = 2'd1;
  localparam logic [1:0] CFG_RESP_NEEDED = 2'd2;

  // Input actions
  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // Message types
  localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] TYPE_DEST_UNREACH = 8'd3;
  localparam logic [7:0] TYPE_REROUTE      = 8'd5;
  localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;

  localparam logic [19:0] MICROS_PER_SEC = 20'd1000000;
  localparam logic [19:0] MICROS_MAX     = 20'd999999;
  localparam logic [7:0]  COUNT_MAX      = 8'd255;

  // One host entry of the table
  typedef struct packed {
    logic [7:0]  count;
    logic [31:0] sum_sec;
    logic [19:0] sum_usec;
  } entry_t;

endpackage

@@ rtl/echo_reply_host_tracker.sv @@
// Per-host echo reply tracker. A packet beat (action 0) is length-checked and
// classified; an echo reply with the current identifier and a sequence number
// naming a host in use is counted and its round-trip time (arrival minus send,
// microseconds borrowed from the seconds) is added to that host's sum. A
// query beat (action 1) returns the first host at or after start_index whose
// reply count is still below responses_needed, or the end of the hosts in use
// if none is. Every item is handled alone by a sequencer around one 32-bit
// add/subtract unit and a host table with one write port and one registered
// read port: a rejected or classified packet goes straight to the result, a
// counted reply takes six unit steps (the table read overlapped with the first
// two) and one write-back, and a query inspects entries in turn, each needing
// one registered table read. After reset and after every configuration write
// the table is swept clear, one entry per cycle; input beats are stalled
// meanwhile. The result register lets a finished result wait while the next beat is taken.
module echo_reply_host_tracker #(
  parameter int HOST_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [12:0] in_packet_bytes,
  input  logic [3:0]  in_header_words,
  input  logic [7:0]  in_message_type,
  input  logic [15:0] in_message_ident,
  input  logic [15:0] in_sequence_number,
  input  logic [31:0] in_sent_seconds,
  input  logic [19:0] in_sent_micros,
  input  logic [31:0] in_arrival_seconds,
  input  logic [19:0] in_arrival_micros,
  input  logic [8:0]  in_start_index,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_host_index,
  output logic [31:0] out_round_trip_seconds,
  output logic [19:0] out_round_trip_micros,
  output logic [8:0]  out_next_index,
  output logic [8:0]  out_pending_hosts,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int IDX_W = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RPL_US,
    S_RPL_SEC,
    S_RPL_UFIX,
    S_RPL_MSUM,
    S_RPL_MCMP,
    S_RPL_SSUM,
    S_RPL_WRITE,
    S_WALK_WAIT,
    S_WALK_CHK,
    S_EMIT
  } state_t;

  state_t state_r;

  // Configuration
  logic [14:0] own_id_r;
  logic [8:0]  host_total_r;
  logic [7:0]  need_r;
  logic [8:0]  pend_r;

  // Host table
  erht_pkg::entry_t mem [HOST_ENTRIES];
  erht_pkg::entry_t mem_q_r;
  logic [IDX_W-1:0] rd_addr_r;
  logic [IDX_W-1:0] clr_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  erht_pkg::entry_t mem_wdata;

  // Working registers
  logic [31:0] ssec_r;
  logic [31:0] asec_r;
  logic [19:0] susec_r;
  logic [19:0] ausec_r;
  logic [19:0] u_r;
  logic        brw_r;
  logic [20:0] m_r;
  logic        cy_r;
  logic [31:0] newsec_r;
  logic [8:0]  scan_r;

  // Result staging
  erht_pkg::status_t res_status_r;
  logic [7:0]  res_hidx_r;
  logic [31:0] res_rsec_r;
  logic [19:0] res_rusec_r;
  logic [8:0]  res_next_r;

  // Result register
  logic        out_valid_r;
  erht_pkg::status_t out_status_r;
  logic [7:0]  out_hidx_r;
  logic [31:0] out_rsec_r;
  logic [19:0] out_rusec_r;
  logic [8:0]  out_next_r;
  logic [8:0]  out_pend_r;

  // ---------------------------------------------------------------------
  // Effective host count: host_total capped at the table depth
  // ---------------------------------------------------------------------
  logic [8:0] n_eff;
  assign n_eff = (32'(host_total_r) < 32'(HOST_ENTRIES)) ? host_total_r : 9'(HOST_ENTRIES);

  // Next register values on a configuration write, used to reload the
  // pending count with what the write leaves behind
  logic [14:0] own_id_nxt;
  logic [8:0]  host_total_nxt;
  logic [7:0]  need_nxt;
  logic        cfg_hit;
  logic [8:0]  n_eff_nxt;

  always_comb begin
    own_id_nxt     = own_id_r;
    host_total_nxt = host_total_r;
    need_nxt       = need_r;
    cfg_hit        = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        erht_pkg::CFG_OWN_ID: begin
          own_id_nxt = cfg_data;
          cfg_hit    = 1'b1;
        end
        erht_pkg::CFG_HOST_TOTAL: begin
          host_total_nxt = cfg_data[8:0];
          cfg_hit        = 1'b1;
        end
        erht_pkg::CFG_RESP_NEEDED: begin
          need_nxt = cfg_data[7:0];
          cfg_hit  = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign n_eff_nxt = (32'(host_total_nxt) < 32'(HOST_ENTRIES)) ? host_total_nxt
                                                                : 9'(HOST_ENTRIES);

  // ---------------------------------------------------------------------
  // Input decode, evaluated on the beat being offered
  // ---------------------------------------------------------------------
  logic        in_acc;
  logic [12:0] min_len;
  logic [15:0] seq_m1;
  logic        bad_index;
  logic        id_match;
  logic [19:0] susec_clamp;
  logic [19:0] ausec_clamp;

  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign min_len     = 13'({in_header_words, 2'b00}) + 13'd8;
  assign seq_m1      = in_sequence_number - 16'd1;
  assign bad_index   = (in_sequence_number == 16'd0) || (seq_m1 >= {7'd0, n_eff});
  assign id_match    = (in_message_ident == {1'b0, own_id_r});
  assign susec_clamp = (in_sent_micros > erht_pkg::MICROS_MAX) ? erht_pkg::MICROS_MAX
                                                                : in_sent_micros;
  assign ausec_clamp = (in_arrival_micros > erht_pkg::MICROS_MAX) ? erht_pkg::MICROS_MAX
                                                                   : in_arrival_micros;

  // ---------------------------------------------------------------------
  // Shared add/subtract unit: a + (b or ~b) + cin, carry out on bit 32
  // ---------------------------------------------------------------------
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_sub;
  logic        alu_cin;
  logic [32:0] alu_sum;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    alu_cin = 1'b0;
    unique case (state_r)
      S_RPL_US: begin
        // arrival micros minus send micros; carry clear means a borrow
        alu_a   = {12'd0, ausec_r};
        alu_b   = {12'd0, susec_r};
        alu_sub = 1'b1;
        alu_cin = 1'b1;
      end
      S_RPL_SEC: begin
        // seconds difference, less the microsecond borrow
        alu_a   = asec_r;
        alu_b   = ssec_r;
        alu_sub = 1'b1;
        alu_cin = !brw_r;
      end
      S_RPL_UFIX: begin
        alu_a = {12'd0, u_r};
        alu_b = brw_r ? {12'd0, erht_pkg::MICROS_PER_SEC} : 32'd0;
      end
      S_RPL_MSUM: begin
        alu_a = {12'd0, mem_q_r.sum_usec};
        alu_b = {12'd0, res_rusec_r};
      end
      S_RPL_MCMP: begin
        alu_a   = {11'd0, m_r};
        alu_b   = {12'd0, erht_pkg::MICROS_PER_SEC};
        alu_sub = 1'b1;
        alu_cin = 1'b1;
      end
      S_RPL_SSUM: begin
        alu_a   = mem_q_r.sum_sec;
        alu_b   = res_rsec_r;
        alu_cin = cy_r;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        alu_cin = 1'b0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {32'd0, alu_cin};

  // ---------------------------------------------------------------------
  // Reply count update, from the entry read back
  // ---------------------------------------------------------------------
  logic [7:0] cnt_new;
  logic       reach;

  assign cnt_new = (mem_q_r.count < erht_pkg::COUNT_MAX) ? mem_q_r.count + 8'd1
                                                          : erht_pkg::COUNT_MAX;
  assign reach   = (mem_q_r.count < need_r) && (cnt_new >= need_r) && (pend_r != 9'd0);

  // Walk step
  logic [8:0] scan_inc;
  assign scan_inc = scan_r + 9'd1;

  // ---------------------------------------------------------------------
  // Table write port: clearing sweep or reply write-back
  // ---------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
    end else if (state_r == S_RPL_WRITE) begin
      mem_we             = 1'b1;
      mem_wdata.count    = cnt_new;
      mem_wdata.sum_sec  = newsec_r;
      mem_wdata.sum_usec = m_r[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[rd_addr_r];
  end

  // ---------------------------------------------------------------------
  // Sequencer, configuration and result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      own_id_r     <= '0;
      host_total_r <= '0;
      need_r       <= 8'd1;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // drop the result once the beat is taken, unless a new one replaces it
      if (out_valid_r && !out_stall && (state_r != S_EMIT || cfg_hit)) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_hit) begin
        // a configuration write clears the table and reloads the pending count
        own_id_r     <= own_id_nxt;
        host_total_r <= host_total_nxt;
        need_r       <= need_nxt;
        pend_r       <= (need_nxt != 8'd0) ? n_eff_nxt : 9'd0;
        clr_r        <= '0;
        state_r      <= S_CLEAR;
      end else begin
        unique case (state_r)
          S_CLEAR: begin
            clr_r <= clr_r + IDX_W'(1);
            if (clr_r == IDX_W'(HOST_ENTRIES - 1)) begin
              state_r <= S_IDLE;
            end
          end

          S_IDLE: begin
            if (in_acc) begin
              res_hidx_r  <= '0;
              res_rsec_r  <= '0;
              res_rusec_r <= '0;
              res_next_r  <= '0;
              ssec_r      <= in_sent_seconds;
              asec_r      <= in_arrival_seconds;
              susec_r     <= susec_clamp;
              ausec_r     <= ausec_clamp;
              state_r     <= S_EMIT;
              if (in_action == erht_pkg::ACT_QUERY) begin
                res_status_r <= erht_pkg::ST_QUERY;
                if (in_start_index >= n_eff) begin
                  res_next_r <= n_eff;
                end else begin
                  scan_r    <= in_start_index;
                  rd_addr_r <= IDX_W'(in_start_index);
                  state_r   <= S_WALK_WAIT;
                end
              end else if (in_packet_bytes < min_len) begin
                res_status_r <= erht_pkg::ST_SHORT;
              end else begin
                case (in_message_type) inside
                  erht_pkg::TYPE_ECHO_REPLY: begin
                    if (!id_match) begin
                      res_status_r <= erht_pkg::ST_FOREIGN;
                    end else if (bad_index) begin
                      res_status_r <= erht_pkg::ST_BAD_INDEX;
                      res_hidx_r   <= seq_m1[7:0];
                    end else begin
                      res_status_r <= erht_pkg::ST_COUNTED;
                      res_hidx_r   <= seq_m1[7:0];
                      rd_addr_r    <= IDX_W'(seq_m1);
                      state_r      <= S_RPL_US;
                    end
                  end
                  erht_pkg::TYPE_ECHO_REQUEST: res_status_r <= erht_pkg::ST_OWN_ECHO;
                  erht_pkg::TYPE_DEST_UNREACH, erht_pkg::TYPE_REROUTE:
                    res_status_r <= erht_pkg::ST_UNREACH;
                  default: res_status_r <= erht_pkg::ST_UNEXPECTED;
                endcase
              end
            end
          end

          S_RPL_US: begin
            u_r     <= alu_sum[19:0];
            brw_r   <= !alu_sum[32];
            state_r <= S_RPL_SEC;
          end

          S_RPL_SEC: begin
            res_rsec_r <= alu_sum[31:0];
            state_r    <= S_RPL_UFIX;
          end

          S_RPL_UFIX: begin
            res_rusec_r <= alu_sum[19:0];
            state_r     <= S_RPL_MSUM;
          end

          S_RPL_MSUM: begin
            m_r     <= alu_sum[20:0];
            state_r <= S_RPL_MCMP;
          end

          S_RPL_MCMP: begin
            // carry out set: the micro sum reached a whole second
            cy_r <= alu_sum[32];
            if (alu_sum[32]) begin
              m_r <= alu_sum[20:0];
            end
            state_r <= S_RPL_SSUM;
          end

          S_RPL_SSUM: begin
            newsec_r <= alu_sum[31:0];
            state_r  <= S_RPL_WRITE;
          end

          S_RPL_WRITE: begin
            if (reach) begin
              pend_r <= pend_r - 9'd1;
            end
            state_r <= S_EMIT;
          end

          S_WALK_WAIT: begin
            state_r <= S_WALK_CHK;
          end

          S_WALK_CHK: begin
            if (mem_q_r.count < need_r) begin
              res_next_r <= scan_r;
              state_r    <= S_EMIT;
            end else if (scan_inc >= n_eff) begin
              res_next_r <= n_eff;
              state_r    <= S_EMIT;
            end else begin
              scan_r    <= scan_inc;
              rd_addr_r <= IDX_W'(scan_inc);
              state_r   <= S_WALK_WAIT;
            end
          end

          S_EMIT: begin
            // hold until the result register is free
            if (!out_valid_r || !out_stall) begin
              out_valid_r  <= 1'b1;
              out_status_r <= res_status_r;
              out_hidx_r   <= res_hidx_r;
              out_rsec_r   <= res_rsec_r;
              out_rusec_r  <= res_rusec_r;
              out_next_r   <= res_next_r;
              out_pend_r   <= pend_r;
              state_r      <= S_IDLE;
            end
          end

          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_host_index         = out_hidx_r;
  assign out_round_trip_seconds = out_rsec_r;
  assign out_round_trip_micros  = out_rusec_r;
  assign out_next_index         = out_next_r;
  assign out_pending_hosts      = out_pend_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pend_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= n_eff)
    else $error("pending count above effective host count");

  a_pend_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cfg_we)) |->
      (pend_r == $past(pend_r) || pend_r == $past(pend_r) - 9'd1))
    else $error("pending count moved by more than one");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again without processing");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside the emit step");

endmodule

@@ sim/tb_echo_reply_host_tracker.sv @@
module tb_echo_reply_host_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOST_ENTRIES = 256;
  // Allow for the longest query walk, the clearing sweep and a long receiver stall, many times
  // over.
  localparam int IDLE_LIMIT = 5000;
  // The clearing sweep after a register write, plus a little margin.
  localparam int SWEEP_CYCLES = HOST_ENTRIES + 8;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // One input beat, field for field as the ports carry it.
  typedef struct packed {
    logic        action;
    logic [12:0] packet_bytes;
    logic [3:0]  header_words;
    logic [7:0]  message_type;
    logic [15:0] message_ident;
    logic [15:0] sequence_number;
    logic [31:0] sent_seconds;
    logic [19:0] sent_micros;
    logic [31:0] arrival_seconds;
    logic [19:0] arrival_micros;
    logic [8:0]  start_index;
  } icmp_beat_t;

  // One result beat, in the order of the output ports.
  typedef struct packed {
    erht_pkg::status_t status;
    logic [7:0]  host_index;
    logic [31:0] rt_sec;
    logic [19:0] rt_usec;
    logic [8:0]  next_index;
    logic [8:0]  pending;
  } host_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [12:0] in_packet_bytes = '0;
  logic [3:0]  in_header_words = '0;
  logic [7:0]  in_message_type = '0;
  logic [15:0] in_message_ident = '0;
  logic [15:0] in_sequence_number = '0;
  logic [31:0] in_sent_seconds = '0;
  logic [19:0] in_sent_micros = '0;
  logic [31:0] in_arrival_seconds = '0;
  logic [19:0] in_arrival_micros = '0;
  logic [8:0]  in_start_index = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_host_index;
  logic [31:0] out_round_trip_seconds;
  logic [19:0] out_round_trip_micros;
  logic [8:0]  out_next_index;
  logic [8:0]  out_pending_hosts;

  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  // Shadow copy of the host table and registers.
  logic [7:0]  seen_replies [HOST_ENTRIES];
  logic [31:0] rtt_sec_sum  [HOST_ENTRIES];
  logic [19:0] rtt_usec_sum [HOST_ENTRIES];
  int unsigned pending_now;
  logic [14:0] cur_own_id;
  logic [8:0]  cur_host_total;
  logic [7:0]  cur_needed;

  host_result_t host_results_q[$];
  int fault_count = 0;
  int burst_left = 0;

  // Receiver stall pattern state.
  int stall_mode = 0;
  int stall_left = 0;
  int run_left = 0;
  logic run_level = 1'b0;

  echo_reply_host_tracker #(
    .HOST_ENTRIES(HOST_ENTRIES)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_packet_bytes        (in_packet_bytes),
    .in_header_words        (in_header_words),
    .in_message_type        (in_message_type),
    .in_message_ident       (in_message_ident),
    .in_sequence_number     (in_sequence_number),
    .in_sent_seconds        (in_sent_seconds),
    .in_sent_micros         (in_sent_micros),
    .in_arrival_seconds     (in_arrival_seconds),
    .in_arrival_micros      (in_arrival_micros),
    .in_start_index         (in_start_index),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_host_index         (out_host_index),
    .out_round_trip_seconds (out_round_trip_seconds),
    .out_round_trip_micros  (out_round_trip_micros),
    .out_next_index         (out_next_index),
    .out_pending_hosts      (out_pending_hosts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  // Hosts actually tracked: the register may ask for more than the table holds.
  function automatic int unsigned hosts_in_use();
    return (cur_host_total > HOST_ENTRIES) ? HOST_ENTRIES : cur_host_total;
  endfunction

  function automatic void clear_hosts();
    for (int i = 0; i < HOST_ENTRIES; i++) begin
      seen_replies[i] = '0;
      rtt_sec_sum[i]  = '0;
      rtt_usec_sum[i] = '0;
    end
  endfunction

  // Apply a register write: any known register clears the table and reloads the pending count.
  function automatic void load_register(input logic [1:0] idx, input logic [14:0] data);
    case (idx)
      erht_pkg::CFG_OWN_ID:      cur_own_id = data;
      erht_pkg::CFG_HOST_TOTAL:  cur_host_total = data[8:0];
      erht_pkg::CFG_RESP_NEEDED: cur_needed = data[7:0];
      default:                   return;
    endcase
    clear_hosts();
    pending_now = (cur_needed > 0) ? hosts_in_use() : 0;
  endfunction

  // Work out the result of one accepted beat and advance the shadow table.
  function automatic host_result_t track_beat(input icmp_beat_t b);
    host_result_t r;
    int unsigned  n;
    int unsigned  idx;
    int           sum_usec;
    logic [15:0]  seq_less_one;
    logic [19:0]  sent_us;
    logic [19:0]  arr_us;
    logic [7:0]   before_cnt;
    r = '0;
    n = hosts_in_use();
    seq_less_one = b.sequence_number - 16'd1;
    if (b.action == erht_pkg::ACT_QUERY) begin
      // Walk from the start host past every host that already has enough replies.
      idx = b.start_index;
      while (idx < n && seen_replies[idx] >= cur_needed) idx++;
      if (idx > n) idx = n;
      r.status = erht_pkg::ST_QUERY;
      r.next_index = 9'(idx);
    end else if (int'(b.packet_bytes) < int'(b.header_words) * 4 + 8) begin
      r.status = erht_pkg::ST_SHORT;
    end else if (b.message_type == erht_pkg::TYPE_ECHO_REPLY) begin
      if (b.message_ident != {1'b0, cur_own_id}) begin
        r.status = erht_pkg::ST_FOREIGN;
      end else if (b.sequence_number == 16'd0 || int'(seq_less_one) >= n) begin
        r.status = erht_pkg::ST_BAD_INDEX;
        r.host_index = seq_less_one[7:0];
      end else begin
        idx = seq_less_one;
        r.status = erht_pkg::ST_COUNTED;
        r.host_index = seq_less_one[7:0];
        // Saturate the count; drop the pending total only on first reaching the goal.
        before_cnt = seen_replies[idx];
        if (before_cnt < erht_pkg::COUNT_MAX) seen_replies[idx] = before_cnt + 8'd1;
        if (before_cnt < cur_needed && seen_replies[idx] >= cur_needed && pending_now > 0)
          pending_now--;
        // Clamp the microseconds, then subtract with a borrow from the seconds.
        sent_us = (b.sent_micros > erht_pkg::MICROS_MAX) ? erht_pkg::MICROS_MAX
                                                         : b.sent_micros;
        arr_us  = (b.arrival_micros > erht_pkg::MICROS_MAX) ? erht_pkg::MICROS_MAX
                                                            : b.arrival_micros;
        r.rt_sec = b.arrival_seconds - b.sent_seconds;
        if (arr_us >= sent_us) begin
          r.rt_usec = arr_us - sent_us;
        end else begin
          r.rt_sec = r.rt_sec - 32'd1;
          r.rt_usec = 20'(int'(arr_us) + int'(erht_pkg::MICROS_PER_SEC) - int'(sent_us));
        end
        // Accumulate with a carry into the seconds sum.
        sum_usec = int'(rtt_usec_sum[idx]) + int'(r.rt_usec);
        rtt_sec_sum[idx] = rtt_sec_sum[idx] + r.rt_sec;
        if (sum_usec >= int'(erht_pkg::MICROS_PER_SEC)) begin
          rtt_sec_sum[idx] = rtt_sec_sum[idx] + 32'd1;
          sum_usec -= int'(erht_pkg::MICROS_PER_SEC);
        end
        rtt_usec_sum[idx] = 20'(sum_usec);
      end
    end else if (b.message_type == erht_pkg::TYPE_ECHO_REQUEST) begin
      r.status = erht_pkg::ST_OWN_ECHO;
    end else if (b.message_type == erht_pkg::TYPE_DEST_UNREACH ||
                 b.message_type == erht_pkg::TYPE_REROUTE) begin
      r.status = erht_pkg::ST_UNREACH;
    end else begin
      r.status = erht_pkg::ST_UNEXPECTED;
    end
    r.pending = 9'(pending_now);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------

  // Every field at full width, every bit free.
  function automatic icmp_beat_t random_beat();
    icmp_beat_t b;
    b.action          = 1'($urandom);
    b.packet_bytes    = 13'($urandom);
    b.header_words    = 4'($urandom);
    b.message_type    = 8'($urandom);
    b.message_ident   = 16'($urandom);
    b.sequence_number = 16'($urandom);
    b.sent_seconds    = $urandom;
    b.sent_micros     = 20'($urandom);
    b.arrival_seconds = $urandom;
    b.arrival_micros  = 20'($urandom);
    b.start_index     = 9'($urandom);
    return b;
  endfunction

  // A well-formed echo reply carrying the current identifier; unused fields stay random.
  function automatic icmp_beat_t reply_beat(input logic [15:0] seq, input logic [31:0] ssec,
                                            input logic [19:0] sus, input logic [31:0] asec,
                                            input logic [19:0] aus);
    icmp_beat_t b;
    b = random_beat();
    b.action          = erht_pkg::ACT_PACKET;
    b.header_words    = 4'd5;
    b.packet_bytes    = 13'd84;
    b.message_type    = erht_pkg::TYPE_ECHO_REPLY;
    b.message_ident   = {1'b0, cur_own_id};
    b.sequence_number = seq;
    b.sent_seconds    = ssec;
    b.sent_micros     = sus;
    b.arrival_seconds = asec;
    b.arrival_micros  = aus;
    return b;
  endfunction

  function automatic icmp_beat_t query_beat(input logic [8:0] start);
    icmp_beat_t b;
    b = random_beat();
    b.action = erht_pkg::ACT_QUERY;
    b.start_index = start;
    return b;
  endfunction

  // Mostly good replies for hosts in use, then queries, then raw noise.
  function automatic icmp_beat_t traffic_beat();
    icmp_beat_t  b;
    int unsigned n;
    int unsigned pick;
    logic [31:0] ssec;
    logic [15:0] seq;
    n = hosts_in_use();
    pick = $urandom_range(0, 99);
    b = random_beat();
    if (pick < 60) begin
      ssec = $urandom;
      seq = (n == 0 || $urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(1, n));
      b = reply_beat(seq, ssec, 20'($urandom_range(0, 999999)),
                     ssec + $urandom_range(0, 3), 20'($urandom_range(0, 999999)));
      b.header_words = 4'($urandom_range(5, 15));
      b.packet_bytes = 13'(int'(b.header_words) * 4 + 8 + $urandom_range(0, 1500));
    end else if (pick < 80) begin
      b = query_beat(($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, n)));
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one beat in bursts: at the end of a burst drop valid for a random gap.
  task automatic send_beat(input icmp_beat_t b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 12);
    end
    in_action          <= b.action;
    in_packet_bytes    <= b.packet_bytes;
    in_header_words    <= b.header_words;
    in_message_type    <= b.message_type;
    in_message_ident   <= b.message_ident;
    in_sequence_number <= b.sequence_number;
    in_sent_seconds    <= b.sent_seconds;
    in_sent_micros     <= b.sent_micros;
    in_arrival_seconds <= b.arrival_seconds;
    in_arrival_micros  <= b.arrival_micros;
    in_start_index     <= b.start_index;
    in_valid           <= 1'b1;
    // Hold the payload until the beat is taken.
    do @(posedge clk); while (in_stall);
    host_results_q.push_back(track_beat(b));
    burst_left--;
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    burst_left = 0;
    while (host_results_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write one register, then sit out the clearing sweep it starts.
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    load_register(idx, data);
    cfg_we <= 1'b0;
    repeat (SWEEP_CYCLES) @(posedge clk);
  endtask

  task automatic run_traffic(input logic [14:0] own, input logic [8:0] total,
                             input logic [7:0] needed, input int beats);
    write_reg(erht_pkg::CFG_OWN_ID, own);
    write_reg(erht_pkg::CFG_HOST_TOTAL, {6'd0, total});
    write_reg(erht_pkg::CFG_RESP_NEEDED, {7'd0, needed});
    repeat (beats) send_beat(traffic_beat());
    settle(4);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    icmp_beat_t b;
    // Reset registers: no hosts, so the query comes straight back with zero.
    send_beat(query_beat(9'd0));
    settle(4);
    write_reg(erht_pkg::CFG_OWN_ID, 15'h7fff);
    write_reg(erht_pkg::CFG_HOST_TOTAL, 15'd4);
    write_reg(erht_pkg::CFG_RESP_NEEDED, 15'd2);
    // Shortest header, nothing received at all.
    b = random_beat();
    b.action = erht_pkg::ACT_PACKET;
    b.packet_bytes = '0;
    b.header_words = '0;
    send_beat(b);
    // Longest header: one byte short, then exactly long enough.
    b = reply_beat(16'd1, 32'd10, 20'd0, 32'd10, 20'd500);
    b.header_words = 4'd15;
    b.packet_bytes = 13'd67;
    send_beat(b);
    b.packet_bytes = 13'd68;
    send_beat(b);
    // Identifier differs only in the top bit.
    b = reply_beat(16'd1, 32'd0, 20'd0, 32'd1, 20'd0);
    b.message_ident = 16'hffff;
    send_beat(b);
    // Sequence zero, one past the hosts in use, and the largest sequence.
    send_beat(reply_beat(16'd0, 32'd0, 20'd0, 32'd0, 20'd0));
    send_beat(reply_beat(16'd5, 32'd0, 20'd0, 32'd0, 20'd0));
    send_beat(reply_beat(16'hffff, 32'd0, 20'd0, 32'd0, 20'd0));
    // Send microseconds out of range, clamped, forcing a borrow.
    send_beat(reply_beat(16'd4, 32'd7, 20'hfffff, 32'd8, 20'd0));
    // Arrival before sending: the seconds wrap.
    send_beat(reply_beat(16'd4, 32'd100, 20'd999999, 32'd50, 20'hfffff));
    // Second and third replies for host 0: goal reached once, sum carries.
    send_beat(reply_beat(16'd1, 32'hffff_ffff, 20'd0, 32'hffff_ffff, 20'd999999));
    send_beat(reply_beat(16'd1, 32'd0, 20'd1, 32'd1, 20'd0));
    // No header words, minimum length.
    b = reply_beat(16'd2, 32'd3, 20'd4, 32'd5, 20'd6);
    b.header_words = '0;
    b.packet_bytes = 13'd8;
    send_beat(b);
    // Every other message type, the largest packet among them.
    b = reply_beat(16'd1, 32'd0, 20'd0, 32'd0, 20'd0);
    b.packet_bytes = 13'h1fff;
    b.message_type = erht_pkg::TYPE_ECHO_REQUEST;
    send_beat(b);
    b.message_type = erht_pkg::TYPE_DEST_UNREACH;
    send_beat(b);
    b.message_type = erht_pkg::TYPE_REROUTE;
    send_beat(b);
    b.message_type = 8'hff;
    send_beat(b);
    b.message_type = 8'd1;
    send_beat(b);
    // Queries: skip a satisfied host, run off the end, start at and beyond the end.
    send_beat(query_beat(9'd0));
    send_beat(query_beat(9'd3));
    send_beat(query_beat(9'd4));
    send_beat(query_beat(9'h1ff));
    settle(4);
  endtask

  // A write to an index past the register list must leave the table alone.
  task automatic test_unused_register();
    write_reg(CFG_UNUSED, 15'h7fff);
    send_beat(query_beat(9'd0));
    send_beat(reply_beat(16'd2, 32'd1, 20'd0, 32'd1, 20'd1));
    send_beat(query_beat(9'd1));
    settle(4);
  endtask

  task automatic test_steady_traffic();
    run_traffic(15'd0, 9'd8, 8'd1, 250);
    run_traffic(15'h7fff, 9'd256, 8'd255, 200);
  endtask

  // One host and the largest goal: the count climbs toward its saturation at 255.
  task automatic test_count_saturation();
    run_traffic(15'($urandom), 9'd1, 8'd255, 450);
  endtask

  task automatic test_table_limits();
    run_traffic(15'($urandom), 9'd0, 8'd3, 100);
    run_traffic(15'($urandom), 9'd300, 8'd1, 350);
    // No replies needed: every query that starts inside the table walks on to its end.
    run_traffic(15'($urandom), 9'h1ff, 8'd0, 150);
  endtask

  task automatic test_random_settings();
    repeat (2)
      run_traffic(15'($urandom), 9'($urandom_range(1, 40)), 8'($urandom_range(0, 6)), 200);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    host_result_t got;
    host_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {erht_pkg::status_t'(out_status), out_host_index, out_round_trip_seconds,
             out_round_trip_micros, out_next_index, out_pending_hosts};
      if (host_results_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected result status=%0d host=%0d", $realtime, got.status,
                   got.host_index);
      end else begin
        want = host_results_q.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: result mismatch expected st=%0d host=%0d rtt=%0d.%06d next=%0d pend=%0d",
                     $realtime, want.status, want.host_index, want.rt_sec, want.rt_usec,
                     want.next_index, want.pending);
            $display("%0t:                 got      st=%0d host=%0d rtt=%0d.%06d next=%0d pend=%0d",
                     $realtime, got.status, got.host_index, got.rt_sec, got.rt_usec,
                     got.next_index, got.pending);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stalls: switch between no stall, light, heavy and long runs
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 30);
          run_level = ~run_level;
        end
        run_left--;
        out_stall <= run_level;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no beat moves on either side for too long
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Register values after reset; the table starts clear.
    cur_own_id = '0;
    cur_host_total = '0;
    cur_needed = 8'd1;
    pending_now = 0;
    clear_hosts();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_unused_register();
    test_steady_traffic();
    test_count_saturation();
    test_table_limits();
    test_random_settings();
    settle(16);
    if (fault_count == 0 && host_results_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
